[rtl/echo_pulse_distance_meter_defines.svh]
// Assertion macros for the echo pulse distance meter checker.
// Depends on nothing; expects clk and arst_n in the scope of each use.
`ifndef ECHO_PULSE_DISTANCE_METER_DEFINES_SVH
`define ECHO_PULSE_DISTANCE_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPDM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("epdm same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EPDM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("epdm next-cycle check failed");

`endif

[rtl/epdm_pkg.sv]
// Package for the echo pulse distance meter: widths, codes and reset values.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package epdm_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CHANNELS   = 2;
	localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int CAP_W   = 16;
	localparam int SCALE_W = 16;
	localparam int DIST_W  = 16;
	localparam int TICKS_W = 17;
	localparam int PROD_W  = TICKS_W + SCALE_W;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 1;
	localparam int M_PAD_W   = M_TDATA_W - DIST_W - TICKS_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [SCALE_W-1:0] SCALE_RST   = 16'd11403;
	localparam logic [DIST_W-1:0]  MAX_RST     = 16'd4000;
	localparam logic [TICKS_W-1:0] TIMEOUT_RST = 17'd22989;

	localparam logic [1:0] OVF_MAX = 2'd2;

	typedef enum logic [1:0] {
		MODE_CAPTURE  = 2'd0,
		MODE_OVERFLOW = 2'd1,
		MODE_TRIGGER  = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE   = 2'd0,
		REG_MAX     = 2'd1,
		REG_TIMEOUT = 2'd2
	} cfg_reg_t;

endpackage

[rtl/echo_pulse_distance_meter.sv]
// Echo pulse distance meter: an accepted request goes through the input register, then
// the width/scale/clamp logic, into the result register. Throughput one request per
// cycle; the input side stalls only while a completing request waits behind a held result.
// arst_n clears all channel state, the valid flags and the config registers to defaults.
// Depends on epdm_pkg.
`timescale 1ns / 1ps

module echo_pulse_distance_meter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [epdm_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] capture_value
	input  logic [epdm_pkg::S_TUSER_W-1:0]    s_tuser,   // [1:0] mode, [2] channel
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [epdm_pkg::M_TDATA_W-1:0]    m_tdata,   // [15:0] distance_mm, [32:16] pulse_ticks
	output logic [epdm_pkg::M_TUSER_W-1:0]    m_tuser,   // [0] out_channel
	input  logic                              cfg_we,
	input  logic [epdm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [epdm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import epdm_pkg::*;

	// Configuration registers
	logic [SCALE_W-1:0] scale_q;
	logic [DIST_W-1:0]  max_q;
	logic [TICKS_W-1:0] timeout_q;

	// Input register stage
	logic                  vld_s1;
	mode_t                 mode_s1;
	logic                  chan_s1;
	logic [TIMER_BITS-1:0] cap_s1;

	// Per-channel measurement state
	logic [TIMER_BITS-1:0] start_q [CHANNELS];
	logic                  armed_q [CHANNELS];
	logic                  done_q  [CHANNELS];
	logic [1:0]            ovf_q   [CHANNELS];

	// Result register
	logic               m_valid_q;
	logic               m_chan_q;
	logic [DIST_W-1:0]  dist_q;
	logic [TICKS_W-1:0] ticks_q;

	logic                  ch_ok;
	logic [CH_IDX_W-1:0]   idx;
	logic                  complete;
	logic                  advance;
	logic [TIMER_BITS-1:0] diff;
	logic [TICKS_W-1:0]    width;
	logic [PROD_W-1:0]     prod;
	logic [TICKS_W-1:0]    scaled;
	logic [DIST_W-1:0]     dist_clamp;

	// Config writes: indexes past the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= SCALE_RST;
			max_q     <= MAX_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCALE:   scale_q   <= cfg_data[SCALE_W-1:0];
				REG_MAX:     max_q     <= cfg_data[DIST_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// A request in s1 completes a measurement when it is a capture on an armed,
	// unfinished channel; only such a request needs room in the result register.
	always_comb begin
		ch_ok    = int'(chan_s1) < CHANNELS;
		idx      = CH_IDX_W'(chan_s1);
		complete = vld_s1 && (mode_s1 == MODE_CAPTURE) && ch_ok
			&& !done_q[idx] && armed_q[idx];
		advance  = vld_s1 && (!complete || !m_valid_q || m_tready);
		s_tready = !vld_s1 || advance;
	end

	// Pulse width. The wrapped width (2^16 - start + end) is exactly the
	// modulo-2^16 difference, so one subtractor serves both cases.
	always_comb begin
		diff = cap_s1 - start_q[idx];
		if ((cap_s1 > start_q[idx]) && (ovf_q[idx] == 2'd0)) begin
			width = TICKS_W'(diff);
		end else if ((cap_s1 < start_q[idx]) && (ovf_q[idx] != OVF_MAX)) begin
			width = TICKS_W'(diff);
		end else begin
			// equal counts or too many wraps: report the timeout width
			width = timeout_q;
		end
		// Scale by the Q0.16 factor, truncate, then clamp.
		prod   = PROD_W'(width) * PROD_W'(scale_q);
		scaled = prod[PROD_W-1:SCALE_W];
		if (scaled > TICKS_W'(max_q)) begin
			dist_clamp = max_q;
		end else begin
			dist_clamp = scaled[DIST_W-1:0];
		end
	end

	// Input register: load whenever the stage is free or moves on this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= mode_t'(s_tuser[1:0]);
			chan_s1 <= s_tuser[2];
			cap_s1  <= s_tdata[TIMER_BITS-1:0];
		end
	end

	// Channel state update as the request leaves s1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				start_q[i] <= '0;
				armed_q[i] <= 1'b0;
				done_q[i]  <= 1'b0;
				ovf_q[i]   <= 2'd0;
			end
		end else if (advance) begin
			unique case (mode_s1)
				MODE_OVERFLOW: begin
					// shared tick: every channel counts, saturating
					for (int i = 0; i < CHANNELS; i++) begin
						if (ovf_q[i] != OVF_MAX) begin
							ovf_q[i] <= ovf_q[i] + 2'd1;
						end
					end
				end
				MODE_CAPTURE: begin
					if (ch_ok && !done_q[idx]) begin
						if (!armed_q[idx]) begin
							// first edge: latch start, restart wrap count
							armed_q[idx] <= 1'b1;
							start_q[idx] <= cap_s1;
							ovf_q[idx]   <= 2'd0;
						end else begin
							// second edge: hold off captures until re-armed
							armed_q[idx] <= 1'b0;
							done_q[idx]  <= 1'b1;
						end
					end
				end
				MODE_TRIGGER: begin
					if (ch_ok) begin
						done_q[idx] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Result register: load on completion, else drop on take, else hold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			m_valid_q <= (advance && complete) || (m_valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && complete) begin
			m_chan_q <= chan_s1;
			dist_q   <= dist_clamp;
			ticks_q  <= width;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, ticks_q, dist_q};
	assign m_tuser  = m_chan_q;

endmodule

[rtl/epdm_checker.sv]
// Port-level checker for the echo pulse distance meter, bound to the top level.
// Depends on epdm_pkg and echo_pulse_distance_meter_defines.svh.
`timescale 1ns / 1ps
`include "echo_pulse_distance_meter_defines.svh"

module epdm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [epdm_pkg::M_TDATA_W-1:0]    m_tdata,
	input logic [epdm_pkg::M_TUSER_W-1:0]    m_tuser
);
	import epdm_pkg::*;

	logic [DIST_W-1:0]  dist_w;
	logic [TICKS_W-1:0] ticks_w;

	assign dist_w  = m_tdata[DIST_W-1:0];
	assign ticks_w = m_tdata[DIST_W+TICKS_W-1:DIST_W];

	// Held result keeps valid and payload.
	`EPDM_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Input side stalls only while a result is held back.
	`EPDM_ASSERT_IMPL(a_ready, !m_tvalid || m_tready, s_tready)

	// A fresh result traces back to an accepted request, through the input and result registers.
	`EPDM_ASSERT_IMPL(a_origin, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

	// The scale is below one, so the distance never exceeds the width.
	`EPDM_ASSERT_IMPL(a_scale, m_tvalid, TICKS_W'(dist_w) <= ticks_w)

endmodule

bind echo_pulse_distance_meter epdm_checker u_epdm_checker (.*);

[tb/sv/tb_echo_pulse_distance_meter.sv]
// Self-checking testbench for the two-channel echo pulse distance meter.
// Depends on epdm_pkg and echo_pulse_distance_meter; predicts every distance report in-line.
`timescale 1ns / 1ps

module tb_echo_pulse_distance_meter;
	import epdm_pkg::*;

	// Mode 3 has no meaning in the block; keep it named for the noise stimulus.
	localparam logic [1:0] MODE_RESERVED = 2'd3;
	localparam int SETTLE_CYCLES = 4;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic              ch;
		logic [DIST_W-1:0]  dist_mm;
		logic [TICKS_W-1:0] ticks;
	} range_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Percent of cycles in which each side holds off.
	int src_idle_pct = 25;
	int sink_idle_pct = 78;
	int mismatches = 0;

	// Predicted ranging state and register copy.
	logic [SCALE_W-1:0] scale_q16 = SCALE_RST;
	logic [DIST_W-1:0]  max_mm = MAX_RST;
	logic [TICKS_W-1:0] timeout_ticks = TIMEOUT_RST;
	logic [15:0] edge_start [CHANNELS] = '{default: '0};
	logic        in_pulse [CHANNELS] = '{default: 1'b0};
	logic        ranged [CHANNELS] = '{default: 1'b0};
	logic [1:0]  wraps [CHANNELS] = '{default: '0};

	range_report_t range_q[$];

	echo_pulse_distance_meter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Advance the ranging state for one accepted request and queue any report it causes.
	task automatic predict_request(input logic [1:0] mode, input logic ch,
			input logic [15:0] cap);
		logic [TICKS_W-1:0] width;
		logic [PROD_W-1:0] prod;
		range_report_t rep;
		if (mode == MODE_OVERFLOW) begin
			// Shared tick: every channel counts the wrap, saturating.
			for (int i = 0; i < CHANNELS; i++)
				if (wraps[i] < OVF_MAX) wraps[i]++;
		end else if (mode == MODE_TRIGGER) begin
			// Re-arm only; a pending first edge stays pending.
			ranged[ch] = 1'b0;
		end else if (mode == MODE_CAPTURE && !ranged[ch]) begin
			if (!in_pulse[ch]) begin
				in_pulse[ch] = 1'b1;
				edge_start[ch] = cap;
				wraps[ch] = '0;
			end else begin
				in_pulse[ch] = 1'b0;
				if (cap > edge_start[ch] && wraps[ch] == 2'd0)
					width = {1'b0, cap - edge_start[ch]};
				else if (cap < edge_start[ch] && wraps[ch] < 2'd2)
					width = 17'h10000 - {1'b0, edge_start[ch]} + {1'b0, cap};
				else
					width = timeout_ticks;
				prod = width * scale_q16;
				rep.ch = ch;
				rep.ticks = width;
				rep.dist_mm = (prod[PROD_W-1:16] > max_mm) ? max_mm : prod[31:16];
				ranged[ch] = 1'b1;
				range_q.push_back(rep);
			end
		end
	endtask

	// Present one request, idling first at random, and hold it until accepted.
	task automatic send_request(input logic [1:0] mode, input logic ch,
			input logic [15:0] cap);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= cap;
		s_tuser <= {ch, mode};
		do @(posedge clk); while (!s_tready);
		predict_request(mode, ch, cap);
	endtask

	// Drop the request line, let every report drain, then let the pipe settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (range_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_SCALE:   scale_q16 = data[SCALE_W-1:0];
			REG_MAX:     max_mm = data[DIST_W-1:0];
			REG_TIMEOUT: timeout_ticks = data[TICKS_W-1:0];
			default:     ;
		endcase
	endtask

	// Reprogram all three registers; only call while idle.
	task automatic write_config(input logic [CFG_DATA_W-1:0] scale,
			input logic [CFG_DATA_W-1:0] max_val, input logic [CFG_DATA_W-1:0] timeout);
		wait_idle();
		write_reg(REG_SCALE, scale);
		write_reg(REG_MAX, max_val);
		write_reg(REG_TIMEOUT, timeout);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed ranging traffic on both channels, with ticks and noise mixed in.
	task automatic send_random_step();
		logic ch;
		logic [15:0] cap;
		int pick;
		int sel;
		ch = 1'($urandom_range(1));
		pick = $urandom_range(99);
		sel = $urandom_range(9);
		if (pick < 15) begin
			send_request(2'($urandom_range(3)), 1'($urandom_range(1)), 16'($urandom));
		end else if (pick < 27) begin
			send_request(MODE_OVERFLOW, ch, 16'($urandom));
		end else if (ranged[ch]) begin
			send_request(MODE_TRIGGER, ch, 16'($urandom));
		end else begin
			if (in_pulse[ch] && sel == 0)
				cap = edge_start[ch];
			else if (in_pulse[ch] && sel < 4)
				cap = edge_start[ch] + 16'($urandom_range(40)) - 16'd20;
			else if (sel == 4)
				cap = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			else
				cap = 16'($urandom);
			send_request(MODE_CAPTURE, ch, cap);
		end
	endtask

	// Hand-picked pulses covering each width rule and each ignore rule.
	task automatic test_directed_cases();
		send_request(MODE_RESERVED, 1'b1, 16'hFFFF);
		send_request(MODE_CAPTURE, 1'b0, 16'd100);
		send_request(MODE_CAPTURE, 1'b0, 16'd1100);
		send_request(MODE_CAPTURE, 1'b0, 16'd5);          // finished channel: ignored
		send_request(MODE_TRIGGER, 1'b0, 16'd0);
		send_request(MODE_CAPTURE, 1'b1, 16'd65000);
		send_request(MODE_OVERFLOW, 1'b0, 16'd0);
		send_request(MODE_CAPTURE, 1'b1, 16'd500);        // one wrap
		send_request(MODE_CAPTURE, 1'b0, 16'h0000);
		send_request(MODE_CAPTURE, 1'b0, 16'hFFFF);       // widest plain pulse, clamped
		send_request(MODE_TRIGGER, 1'b0, 16'd0);
		send_request(MODE_TRIGGER, 1'b1, 16'd0);
		send_request(MODE_CAPTURE, 1'b0, 16'd7);
		send_request(MODE_CAPTURE, 1'b0, 16'd7);          // equal counts: timeout
		send_request(MODE_CAPTURE, 1'b1, 16'd10);
		send_request(MODE_OVERFLOW, 1'b1, 16'd0);
		send_request(MODE_CAPTURE, 1'b1, 16'd20);         // later count after a wrap: timeout
		send_request(MODE_TRIGGER, 1'b0, 16'd0);
		send_request(MODE_TRIGGER, 1'b1, 16'd0);
		send_request(MODE_CAPTURE, 1'b0, 16'd40000);
		send_request(MODE_OVERFLOW, 1'b0, 16'd0);
		send_request(MODE_OVERFLOW, 1'b0, 16'd0);
		send_request(MODE_CAPTURE, 1'b0, 16'd30000);      // two wraps: timeout
		send_request(MODE_CAPTURE, 1'b1, 16'hFFFF);
		send_request(MODE_TRIGGER, 1'b1, 16'd0);          // first edge stays pending
		send_request(MODE_CAPTURE, 1'b1, 16'h0000);
	endtask

	// Walk the registers through their extremes with short random bursts at each.
	task automatic test_register_extremes();
		write_config(17'd0, 17'd0, 17'd0);
		repeat (30) send_random_step();
		write_config(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
		repeat (30) send_random_step();
		write_config(17'd65535, 17'd100, 17'd1);
		repeat (30) send_random_step();
		write_config(17'd1, 17'd65535, 17'd65535);
		repeat (30) send_random_step();
		write_config(SCALE_RST, MAX_RST, TIMEOUT_RST);
		repeat (30) send_random_step();
	endtask

	// Long random run in three idling phases with fresh register values each time.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 78 : 0;
			sink_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 25 : 0;
			write_config(17'($urandom),
				$urandom_range(1) ? 17'($urandom) : 17'($urandom_range(5000)),
				17'($urandom));
			repeat (130) send_random_step();
		end
	endtask

	// Stall the report side at random and compare every accepted report.
	always @(posedge clk) begin : report_check
		range_report_t want;
		range_report_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.ch = m_tuser[0];
			got.dist_mm = m_tdata[DIST_W-1:0];
			got.ticks = m_tdata[DIST_W+TICKS_W-1:DIST_W];
			if (range_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected report: ch=%0d dist=%0d ticks=%0d",
						got.ch, got.dist_mm, got.ticks);
			end else begin
				want = range_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"report mismatch: expected ch=%0d dist=%0d ticks=%0d,",
							" got ch=%0d dist=%0d ticks=%0d"},
							want.ch, want.dist_mm, want.ticks,
							got.ch, got.dist_mm, got.ticks);
				end
			end
		end
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_register_extremes();
		test_random_traffic();
		wait_idle();
		if (mismatches == 0 && range_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#(2_000_000);
		$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/epdm_pkg.sv
rtl/echo_pulse_distance_meter.sv
rtl/epdm_checker.sv
tb/sv/tb_echo_pulse_distance_meter.sv
